// ===== sv/crbc_pkg.sv =====
// Shared types, constants and the arctangent table for the circle versus rotated box core.
// Depends on nothing; every other file in this folder imports it.
package crbc_pkg;

   // Fixed-point layout of coordinates and trig values
   localparam int FRAC_BITS     = 16;
   localparam int TRIG_BITS     = 18;
   localparam int PHASE_BITS    = 32;
   localparam int CORDIC_BITS   = 34;
   localparam int CORDIC_Z_BITS = 32;
   localparam int CORDIC_STEPS  = 24;
   localparam int STEP_BITS     = 5;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic signed [CORDIC_BITS-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [TRIG_BITS-1:0]   TRIG_ONE    = 18'sd65536;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RECT_CENTER_X = 3'd0,
      CSR_RECT_CENTER_Y = 3'd1,
      CSR_RECT_ANGLE    = 3'd2,
      CSR_RECT_WIDTH    = 3'd3,
      CSR_RECT_HEIGHT   = 3'd4
   } csr_index_type;

   // Sine/cosine sequencer states
   typedef enum logic [1:0] {
      TRIG_IDLE,
      TRIG_ROTATE,
      TRIG_FINISH
   } trig_state_type;

   // Quadrant of the binary angle
   typedef enum logic [1:0] {
      QUAD_FIRST  = 2'd0,
      QUAD_SECOND = 2'd1,
      QUAD_THIRD  = 2'd2,
      QUAD_FOURTH = 2'd3
   } quadrant_type;

   // Load enables of the three rotation stages
   typedef struct packed {
      logic diff;
      logic prod;
      logic sum;
   } stage_load_type;

   // Arctangent of 2^-i as a 32-bit phase (2^32 per turn)
   function automatic logic [PHASE_BITS-3:0] atan_phase(input logic [STEP_BITS-1:0] step);
      logic [PHASE_BITS-3:0] value;
      unique case (step)
         5'd0:    value = 30'h20000000;
         5'd1:    value = 30'h12E4051E;
         5'd2:    value = 30'h09FB385B;
         5'd3:    value = 30'h051111D4;
         5'd4:    value = 30'h028B0D43;
         5'd5:    value = 30'h0145D7E1;
         5'd6:    value = 30'h00A2F61E;
         5'd7:    value = 30'h00517C55;
         5'd8:    value = 30'h0028BE53;
         5'd9:    value = 30'h00145F2F;
         5'd10:   value = 30'h000A2F98;
         5'd11:   value = 30'h000517CC;
         5'd12:   value = 30'h00028BE6;
         5'd13:   value = 30'h000145F3;
         5'd14:   value = 30'h0000A2FA;
         5'd15:   value = 30'h0000517D;
         5'd16:   value = 30'h000028BE;
         5'd17:   value = 30'h0000145F;
         5'd18:   value = 30'h00000A30;
         5'd19:   value = 30'h00000518;
         5'd20:   value = 30'h0000028C;
         5'd21:   value = 30'h00000146;
         5'd22:   value = 30'h000000A3;
         5'd23:   value = 30'h00000051;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

// ===== sv/crbc_trig.sv =====
// Iterative CORDIC that turns the rectangle angle into Q1.16 cosine and sine.
// Depends on crbc_pkg for the arctangent table, gain and sequencer states.
module crbc_trig import crbc_pkg::*; #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ANGLE_BITS-1:0]       angle,
   output logic                        busy,
   output logic signed [TRIG_BITS-1:0] cos_val,
   output logic signed [TRIG_BITS-1:0] sin_val
);

   localparam int PHASE_PAD = PHASE_BITS - ANGLE_BITS;

   trig_state_type                   state_ff, state_in;
   logic [STEP_BITS-1:0]             step_ff, step_in;
   logic signed [CORDIC_BITS-1:0]    x_ff, x_in, y_ff, y_in;
   logic signed [CORDIC_Z_BITS-1:0]  z_ff, z_in;
   quadrant_type                     quad_ff, quad_in;
   logic signed [TRIG_BITS-1:0]      cos_ff, cos_in, sin_ff, sin_in;

   logic [PHASE_BITS-1:0]            phase;
   logic [PHASE_BITS-3:0]            rest;
   logic signed [CORDIC_BITS-1:0]    x_shift, y_shift, x_round, y_round;
   logic signed [CORDIC_Z_BITS-1:0]  atan_step;
   logic signed [TRIG_BITS-1:0]      cos_base, sin_base;
   quadrant_type                     quad_sel;
   logic                             load_trig;

   // Clamp a rounded CORDIC output to plus or minus one
   function automatic logic signed [TRIG_BITS-1:0] clamp_trig(
      input logic signed [CORDIC_BITS-15:0] value
   );
      logic signed [TRIG_BITS-1:0] result;
      if (value > 20'sd65536) begin
         result = TRIG_ONE;
      end else if (value < -20'sd65536) begin
         result = -TRIG_ONE;
      end else begin
         result = value[TRIG_BITS-1:0];
      end
      return result;
   endfunction

   assign phase   = {angle, {PHASE_PAD{1'b0}}};
   assign rest    = phase[PHASE_BITS-3:0];
   assign busy    = (state_ff != TRIG_IDLE);
   assign cos_val = cos_ff;
   assign sin_val = sin_ff;

   // One micro-rotation per cycle
   assign x_shift   = x_ff >>> step_ff;
   assign y_shift   = y_ff >>> step_ff;
   assign atan_step = $signed({2'b00, atan_phase(step_ff)});

   // Round Q3.30 to Q1.16: add half an LSB, drop 14 bits
   assign x_round = x_ff + 34'sd8192;
   assign y_round = y_ff + 34'sd8192;

   // Pick the quadrant-zero pair and fold it into the right quadrant
   always_comb begin
      if (start) begin
         cos_base  = TRIG_ONE;
         sin_base  = '0;
         quad_sel  = quadrant_type'(phase[PHASE_BITS-1 -: 2]);
         load_trig = (rest == '0);
      end else begin
         cos_base  = clamp_trig(x_round[CORDIC_BITS-1:14]);
         sin_base  = clamp_trig(y_round[CORDIC_BITS-1:14]);
         quad_sel  = quad_ff;
         load_trig = (state_ff == TRIG_FINISH);
      end
      unique case (quad_sel)
         QUAD_FIRST: begin
            cos_in = cos_base;
            sin_in = sin_base;
         end
         QUAD_SECOND: begin
            cos_in = -sin_base;
            sin_in = cos_base;
         end
         QUAD_THIRD: begin
            cos_in = -cos_base;
            sin_in = -sin_base;
         end
         default: begin
            cos_in = sin_base;
            sin_in = -cos_base;
         end
      endcase
   end

   // Sequencer: a new angle restarts the rotation at any time
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      quad_in  = quad_ff;
      if (start) begin
         state_in = (rest == '0) ? TRIG_IDLE : TRIG_ROTATE;
         step_in  = '0;
         x_in     = CORDIC_GAIN;
         y_in     = '0;
         z_in     = $signed({2'b00, rest});
         quad_in  = quadrant_type'(phase[PHASE_BITS-1 -: 2]);
      end else begin
         unique case (state_ff)
            TRIG_ROTATE: begin
               if (!z_ff[CORDIC_Z_BITS-1]) begin
                  x_in = x_ff - y_shift;
                  y_in = y_ff + x_shift;
                  z_in = z_ff - atan_step;
               end else begin
                  x_in = x_ff + y_shift;
                  y_in = y_ff - x_shift;
                  z_in = z_ff + atan_step;
               end
               step_in = step_ff + 1'b1;
               if (step_ff == STEP_BITS'(CORDIC_STEPS - 1)) begin
                  state_in = TRIG_FINISH;
               end
            end
            TRIG_FINISH: state_in = TRIG_IDLE;
            default:     state_in = TRIG_IDLE;
         endcase
      end
   end

   // Sequencer and trig registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TRIG_IDLE;
         cos_ff   <= TRIG_ONE;
         sin_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (load_trig) begin
            cos_ff <= cos_in;
            sin_ff <= sin_in;
         end
      end
   end

   // Iteration datapath
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      quad_ff <= quad_in;
   end

endmodule

// ===== sv/crbc_rotate.sv =====
// Three-stage datapath: offset from the box centre, four products, rounded sums.
// Depends on crbc_pkg for the fraction width, trig width and stage load struct.
module crbc_rotate import crbc_pkg::*; #(
   parameter int COORD_BITS = 32
) (
   input  logic                          clock,
   input  stage_load_type                load,
   input  logic signed [COORD_BITS-1:0]  body_x,
   input  logic signed [COORD_BITS-1:0]  body_y,
   input  logic [COORD_BITS-2:0]         body_radius,
   input  logic signed [COORD_BITS-1:0]  center_x,
   input  logic signed [COORD_BITS-1:0]  center_y,
   input  logic signed [TRIG_BITS-1:0]   cos_val,
   input  logic signed [TRIG_BITS-1:0]   sin_val,
   output logic [COORD_BITS-2:0]         radius,
   output logic signed [COORD_BITS+3:0]  local_x,
   output logic signed [COORD_BITS+3:0]  local_y
);

   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = DIFF_BITS + TRIG_BITS;
   localparam int SUM_BITS  = PROD_BITS + 1;

   logic signed [DIFF_BITS-1:0] dx_ff, dy_ff;
   logic signed [PROD_BITS-1:0] cdx_ff, sdy_ff, sdx_ff, cdy_ff;
   logic signed [SUM_BITS-1:0]  sum_x, sum_y;
   logic signed [COORD_BITS+3:0] lx_ff, ly_ff;
   logic [COORD_BITS-2:0]       rad1_ff, rad2_ff, rad3_ff;

   // Stage 1: circle centre relative to the box centre
   always_ff @(posedge clock) begin
      if (load.diff) begin
         dx_ff   <= DIFF_BITS'(body_x) - DIFF_BITS'(center_x);
         dy_ff   <= DIFF_BITS'(body_y) - DIFF_BITS'(center_y);
         rad1_ff <= body_radius;
      end
   end

   // Stage 2: the four rotation products
   always_ff @(posedge clock) begin
      if (load.prod) begin
         cdx_ff  <= PROD_BITS'(cos_val) * PROD_BITS'(dx_ff);
         sdy_ff  <= PROD_BITS'(sin_val) * PROD_BITS'(dy_ff);
         sdx_ff  <= PROD_BITS'(sin_val) * PROD_BITS'(dx_ff);
         cdy_ff  <= PROD_BITS'(cos_val) * PROD_BITS'(dy_ff);
         rad2_ff <= rad1_ff;
      end
   end

   // Stage 3: sum, add half an LSB and drop the product fraction
   assign sum_x = SUM_BITS'(cdx_ff) - SUM_BITS'(sdy_ff) + SUM_BITS'(1 << (FRAC_BITS - 1));
   assign sum_y = SUM_BITS'(sdx_ff) + SUM_BITS'(cdy_ff) + SUM_BITS'(1 << (FRAC_BITS - 1));

   always_ff @(posedge clock) begin
      if (load.sum) begin
         lx_ff   <= sum_x[SUM_BITS-1:FRAC_BITS];
         ly_ff   <= sum_y[SUM_BITS-1:FRAC_BITS];
         rad3_ff <= rad2_ff;
      end
   end

   assign radius  = rad3_ff;
   assign local_x = lx_ff;
   assign local_y = ly_ff;

endmodule

// ===== sv/crbc_judge.sv =====
// Output stage: overlap test on the exact local point, then saturation to the port range.
// Depends on crbc_pkg (imported for the shared house conventions).
module crbc_judge import crbc_pkg::*; #(
   parameter int COORD_BITS = 32
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic [COORD_BITS-2:0]         radius,
   input  logic signed [COORD_BITS+3:0]  local_x,
   input  logic signed [COORD_BITS+3:0]  local_y,
   input  logic [COORD_BITS-2:0]         rect_width,
   input  logic [COORD_BITS-2:0]         rect_height,
   output logic                          hit,
   output logic signed [COORD_BITS-1:0]  sat_x,
   output logic signed [COORD_BITS-1:0]  sat_y
);

   localparam int LOCAL_BITS = COORD_BITS + 4;
   localparam int CMP_BITS   = LOCAL_BITS + 1;
   localparam int TOP_BITS   = LOCAL_BITS - COORD_BITS + 1;

   localparam logic signed [COORD_BITS-1:0] SAT_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] SAT_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   logic [LOCAL_BITS-1:0] mag_x, mag_y;
   logic [CMP_BITS-1:0]   twice_x, twice_y, bound_x, bound_y;
   logic [TOP_BITS-1:0]   top_x, top_y;
   logic                  inside_x, inside_y;
   logic signed [COORD_BITS-1:0] clip_x, clip_y;
   logic                  hit_ff;
   logic signed [COORD_BITS-1:0] sat_x_ff, sat_y_ff;

   // Compare 2*|l| against 2*radius + size, no rounding involved
   assign mag_x    = local_x[LOCAL_BITS-1] ? LOCAL_BITS'(-local_x) : LOCAL_BITS'(local_x);
   assign mag_y    = local_y[LOCAL_BITS-1] ? LOCAL_BITS'(-local_y) : LOCAL_BITS'(local_y);
   assign twice_x  = {mag_x, 1'b0};
   assign twice_y  = {mag_y, 1'b0};
   assign bound_x  = CMP_BITS'({radius, 1'b0}) + CMP_BITS'(rect_width);
   assign bound_y  = CMP_BITS'({radius, 1'b0}) + CMP_BITS'(rect_height);
   assign inside_x = (twice_x < bound_x);
   assign inside_y = (twice_y < bound_y);

   // Clamp to the signed port range when the upper bits are not pure sign
   assign top_x  = local_x[LOCAL_BITS-1:COORD_BITS-1];
   assign top_y  = local_y[LOCAL_BITS-1:COORD_BITS-1];
   assign clip_x = ((&top_x) || !(|top_x)) ? local_x[COORD_BITS-1:0]
                 : (local_x[LOCAL_BITS-1] ? SAT_MIN : SAT_MAX);
   assign clip_y = ((&top_y) || !(|top_y)) ? local_y[COORD_BITS-1:0]
                 : (local_y[LOCAL_BITS-1] ? SAT_MIN : SAT_MAX);

   // Result register
   always_ff @(posedge clock) begin
      if (load) begin
         hit_ff   <= inside_x && inside_y;
         sat_x_ff <= clip_x;
         sat_y_ff <= clip_y;
      end
   end

   assign hit   = hit_ff;
   assign sat_x = sat_x_ff;
   assign sat_y = sat_y_ff;

endmodule

// ===== sv/circle_rotated_box_collision_core.sv =====
// Circle versus rotated rectangle overlap test.
// Request channel (req_valid/req_stall): one circle per transaction, centre and radius
// in Q16.16. Response channel (rsp_valid/rsp_stall): hit flag plus the circle centre
// in the rectangle frame, saturated to the coordinate range.
// Throughput: one transaction per cycle while req_stall is low. A request passes through
// the offset, products, sums and test registers, in that order, to the response.
// Each stage holds its item only while the stage behind it is full and blocked, so a
// response stalled at the output still lets the stages in front of it fill up; req_stall
// rises once all four stages are occupied behind a stalled response.
// Configuration: csr_write with csr_index/csr_data, one register per write. The user must
// write only while no transaction is in flight; the block itself does not enforce it.
// Writing the angle starts the sine/cosine CORDIC: the write loads it, then the
// micro-rotations and a rounding step follow; req_stall stays high until cosine and
// sine are loaded. A quadrant-boundary angle needs no iterations and is ready at once.
// Reset (synchronous): the configuration registers read zero, cosine is one and sine
// zero, the pipeline is empty and no response is valid.
// Depends on crbc_pkg, crbc_trig, crbc_rotate and crbc_judge.
module circle_rotated_box_collision_core import crbc_pkg::*; #(
   parameter int COORD_BITS = 32,
   parameter int ANGLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_BITS-1:0]  req_body_x,
   input  logic signed [COORD_BITS-1:0]  req_body_y,
   input  logic [COORD_BITS-2:0]         req_body_radius,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic signed [COORD_BITS-1:0]  rsp_local_x,
   output logic signed [COORD_BITS-1:0]  rsp_local_y,
   input  logic                          csr_write,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [((COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS)-1:0] csr_data
);

   logic signed [COORD_BITS-1:0]  center_x_ff, center_y_ff;
   logic [COORD_BITS-2:0]         width_ff, height_ff;
   logic                          diff_valid_ff, prod_valid_ff, sum_valid_ff, rsp_valid_ff;

   logic                          trig_start, trig_busy;
   logic signed [TRIG_BITS-1:0]   cos_val, sin_val;
   stage_load_type                load;
   logic                          load_out, accept;
   logic [COORD_BITS-2:0]         radius;
   logic signed [COORD_BITS+3:0]  local_x, local_y;

   // Configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_RECT_CENTER_X: center_x_ff <= csr_data[COORD_BITS-1:0];
            CSR_RECT_CENTER_Y: center_y_ff <= csr_data[COORD_BITS-1:0];
            CSR_RECT_WIDTH:    width_ff    <= csr_data[COORD_BITS-2:0];
            CSR_RECT_HEIGHT:   height_ff   <= csr_data[COORD_BITS-2:0];
            default: ;
         endcase
      end
   end

   assign trig_start = csr_write && (csr_index_type'(csr_index) == CSR_RECT_ANGLE);

   crbc_trig #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_trig (
      .clock   (clock),
      .reset   (reset),
      .start   (trig_start),
      .angle   (csr_data[ANGLE_BITS-1:0]),
      .busy    (trig_busy),
      .cos_val (cos_val),
      .sin_val (sin_val)
   );

   // Stage advance: a stage loads when it is empty or its successor loads
   assign load_out  = !rsp_valid_ff || !rsp_stall;
   assign load.sum  = !sum_valid_ff  || load_out;
   assign load.prod = !prod_valid_ff || load.sum;
   assign load.diff = !diff_valid_ff || load.prod;
   assign req_stall = !load.diff || trig_busy;
   assign accept    = req_valid && !req_stall;

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         diff_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (load.diff) diff_valid_ff <= accept;
         if (load.prod) prod_valid_ff <= diff_valid_ff;
         if (load.sum)  sum_valid_ff  <= prod_valid_ff;
         if (load_out)  rsp_valid_ff  <= sum_valid_ff;
      end
   end

   crbc_rotate #(
      .COORD_BITS (COORD_BITS)
   ) u_rotate (
      .clock       (clock),
      .load        (load),
      .body_x      (req_body_x),
      .body_y      (req_body_y),
      .body_radius (req_body_radius),
      .center_x    (center_x_ff),
      .center_y    (center_y_ff),
      .cos_val     (cos_val),
      .sin_val     (sin_val),
      .radius      (radius),
      .local_x     (local_x),
      .local_y     (local_y)
   );

   crbc_judge #(
      .COORD_BITS (COORD_BITS)
   ) u_judge (
      .clock       (clock),
      .load        (load_out),
      .radius      (radius),
      .local_x     (local_x),
      .local_y     (local_y),
      .rect_width  (width_ff),
      .rect_height (height_ff),
      .hit         (rsp_hit),
      .sat_x       (rsp_local_x),
      .sat_y       (rsp_local_y)
   );

   assign rsp_valid = rsp_valid_ff;

   // An accepted transaction always lands in the first stage
   assert property (@(posedge clock) disable iff (reset) accept |=> diff_valid_ff)
      else $error("accepted transaction missing from first stage");

   // A finished sum moves into an empty output register
   assert property (@(posedge clock) disable iff (reset)
      (sum_valid_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished transaction not moved to output");

   // A full pipeline behind a stalled response pushes back on requests
   assert property (@(posedge clock) disable iff (reset)
      (diff_valid_ff && prod_valid_ff && sum_valid_ff && rsp_valid_ff && rsp_stall)
      |-> req_stall)
      else $error("request taken while pipeline full and blocked");

endmodule
